// ===== rtl/morse_text_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// Morse text decoder assertion macros
// Concurrent check wrappers shared by the decoder modules.
// ----------------------------------------------------------------------------
`ifndef MORSE_TEXT_DECODER_DEFINES_SVH
`define MORSE_TEXT_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
// check on every edge outside reset
`define MTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check on every edge, reset included
`define MTD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MTD_ASSERT(lbl, prop, msg)
`define MTD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/mtd_pkg.sv =====
// ----------------------------------------------------------------------------
// Morse text decoder package
// Character codes, result types and the letter/digit code table.
// ----------------------------------------------------------------------------
package mtd_pkg;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_DASH  = 8'd45;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_HASH  = 8'd35;
  localparam logic [7:0] CH_STAR  = 8'd42;

  localparam int NUM_CODES  = 36;
  localparam int FIFO_DEPTH = 4;

  // code length in symbols, dash pattern (first symbol in bit 0), character
  localparam logic [3:0] CODE_LEN [NUM_CODES] = '{
    4'd2, 4'd4, 4'd4, 4'd3, 4'd1, 4'd4, 4'd3, 4'd4, 4'd2, 4'd4,
    4'd3, 4'd4, 4'd2, 4'd2, 4'd3, 4'd4, 4'd4, 4'd3, 4'd3, 4'd1,
    4'd3, 4'd4, 4'd3, 4'd4, 4'd4, 4'd4,
    4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5
  };
  localparam logic [7:0] CODE_BITS [NUM_CODES] = '{
    8'd2, 8'd1, 8'd5, 8'd1, 8'd0, 8'd4, 8'd3, 8'd0, 8'd0, 8'd14,
    8'd5, 8'd2, 8'd3, 8'd1, 8'd7, 8'd6, 8'd11, 8'd2, 8'd0, 8'd1,
    8'd4, 8'd8, 8'd6, 8'd9, 8'd13, 8'd3,
    8'd31, 8'd30, 8'd28, 8'd24, 8'd16, 8'd0, 8'd1, 8'd3, 8'd7, 8'd15
  };
  localparam logic [7:0] CODE_CHAR [NUM_CODES] = '{
    "a", "b", "c", "d", "e", "f", "g", "h", "i", "j",
    "k", "l", "m", "n", "o", "p", "q", "r", "s", "t",
    "u", "v", "w", "x", "y", "z",
    "0", "1", "2", "3", "4", "5", "6", "7", "8", "9"
  };

  // one output word
  typedef struct packed {
    logic [7:0] out_char;
    logic       invalid_code;
    logic       last;
  } result_t;

  // results caused by one input word
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } result_pair_t;

  // decode a finished token into a character and its invalid flag
  function automatic result_t decode_token(input logic [7:0] bits,
                                           input logic [3:0] count,
                                           input logic       slash,
                                           input logic       foreign);
    result_t    r;
    logic       hit;
    logic [7:0] ch;
    hit = 1'b0;
    ch  = 8'd0;
    for (int i = 0; i < NUM_CODES; i++) begin
      if (CODE_LEN[i] == count && CODE_BITS[i] == bits) begin
        hit = 1'b1;
        ch  = ch | CODE_CHAR[i];
      end
    end
    r.last = 1'b0;
    if (foreign) begin
      r.out_char     = CH_STAR;
      r.invalid_code = 1'b1;
    end else if (slash) begin
      r.out_char     = (count == 4'd1) ? CH_SPACE : CH_STAR;
      r.invalid_code = (count != 4'd1);
    end else if (count == 4'd8 && bits == 8'd0) begin
      r.out_char     = CH_HASH;
      r.invalid_code = 1'b0;
    end else if (hit) begin
      r.out_char     = ch;
      r.invalid_code = 1'b0;
    end else begin
      r.out_char     = CH_STAR;
      r.invalid_code = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/morse_text_decoder.sv =====
// A word accepted on s_axis sits in the input register; its results are pushed
// into the result queue when the queue has room for a pair, and the queue's
// head word is offered on m_axis.
// Throughput: one input word per cycle while the result queue has room for a
// pair; a word that yields two results drains as two output words.
// Reset (rst, synchronous, active high) clears the token, the line state,
// the input register and the result queue.
// ----------------------------------------------------------------------------
// Morse text decoder
// Streams Morse text bytes in and decoded characters out.
// ----------------------------------------------------------------------------
module morse_text_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
  input  logic       s_axis_tlast,   // end_of_stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tuser,   // invalid_code
  output logic       m_axis_tlast    // last
);
  import mtd_pkg::*;

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         in_eos;
  logic         take;
  logic         room;
  result_pair_t res;
  result_t      head_word;

  // consume the held word when the queue can take a pair
  assign take          = in_valid && room;
  assign s_axis_tready = !in_valid || take;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_eos  <= s_axis_tlast;
    end
  end

  mtd_token u_token (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .text_byte    (in_byte),
    .end_of_stream(in_eos),
    .res          (res)
  );

  mtd_result_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_num (take ? res.num : 2'd0),
    .push_data(res),
    .room     (room),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (head_word)
  );

  assign m_axis_tdata = head_word.out_char;
  assign m_axis_tuser = head_word.invalid_code;
  assign m_axis_tlast = head_word.last;

endmodule

// ===== rtl/mtd_token.sv =====
// ----------------------------------------------------------------------------
// Morse token tracker
// Holds the token being built and the line state; decodes up to two results
// for the word taken this cycle.
// ----------------------------------------------------------------------------
`include "morse_text_decoder_defines.svh"

module mtd_token (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           text_byte,
  input  logic                 end_of_stream,
  output mtd_pkg::result_pair_t res
);
  import mtd_pkg::*;

  logic [7:0] symbol_bits, symbol_bits_next;
  logic [3:0] symbol_count, symbol_count_next;
  logic       slash_seen, slash_seen_next;
  logic       foreign_seen, foreign_seen_next;
  logic       line_open, line_open_next;

  logic       pending;
  result_t    tok;
  result_t    nl;

  assign pending = (symbol_count != 4'd0);
  assign tok     = decode_token(symbol_bits, symbol_count, slash_seen, foreign_seen);
  assign nl      = '{out_char: CH_NL, invalid_code: 1'b0, last: 1'b0};

  // pick the results for this word
  always_comb begin
    res.num    = 2'd0;
    res.first  = tok;
    res.second = nl;
    if (end_of_stream) begin
      if (pending) begin
        res.num = line_open ? 2'd2 : 2'd1;
      end else if (line_open) begin
        res.first = nl;
        res.num   = 2'd1;
      end
    end else if (text_byte == CH_NL) begin
      if (pending) begin
        res.num = 2'd2;
      end else begin
        res.first = nl;
        res.num   = 2'd1;
      end
    end else if (text_byte == CH_SPACE) begin
      res.num = pending ? 2'd1 : 2'd0;
    end
    res.first.last  = (res.num == 2'd1);
    res.second.last = 1'b1;
  end

  // advance token and line state
  always_comb begin
    symbol_bits_next  = symbol_bits;
    symbol_count_next = symbol_count;
    slash_seen_next   = slash_seen;
    foreign_seen_next = foreign_seen;
    line_open_next    = line_open;
    if (end_of_stream || text_byte == CH_NL || text_byte == CH_SPACE) begin
      symbol_bits_next  = 8'd0;
      symbol_count_next = 4'd0;
      slash_seen_next   = 1'b0;
      foreign_seen_next = 1'b0;
      line_open_next    = !end_of_stream && (text_byte == CH_SPACE);
    end else begin
      line_open_next = 1'b1;
      if (text_byte == CH_DASH) begin
        if (!symbol_count[3]) begin
          symbol_bits_next[symbol_count[2:0]] = 1'b1;
        end
      end else if (text_byte == CH_SLASH) begin
        slash_seen_next = 1'b1;
      end else if (text_byte != CH_DOT) begin
        foreign_seen_next = 1'b1;
      end
      if (symbol_count != 4'd15) begin
        symbol_count_next = symbol_count + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_bits  <= 8'd0;
      symbol_count <= 4'd0;
      slash_seen   <= 1'b0;
      foreign_seen <= 1'b0;
      line_open    <= 1'b0;
    end else if (take) begin
      symbol_bits  <= symbol_bits_next;
      symbol_count <= symbol_count_next;
      slash_seen   <= slash_seen_next;
      foreign_seen <= foreign_seen_next;
      line_open    <= line_open_next;
    end
  end

  `MTD_ASSERT(a_eos_clears, take && end_of_stream |=> symbol_count == 4'd0 && !line_open, "end of stream left state behind")
  `MTD_ASSERT(a_pair_last, take && res.num == 2'd2 |-> !res.first.last && res.second.last, "last flag misplaced on result pair")
  `MTD_ASSERT(a_bits_in_token, symbol_count < 4'd8 |-> (symbol_bits >> symbol_count) == 8'd0, "dash bits beyond token length")

endmodule

// ===== rtl/mtd_result_fifo.sv =====
// ----------------------------------------------------------------------------
// Morse result queue
// Small queue that takes up to two result words a cycle and hands out one.
// ----------------------------------------------------------------------------
`include "morse_text_decoder_defines.svh"

module mtd_result_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            push_num,
  input  mtd_pkg::result_pair_t push_data,
  output logic                  room,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mtd_pkg::result_t      out_data
);
  import mtd_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  result_t            slots [FIFO_DEPTH];
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   tail;
  logic [CNT_W-1:0]   count, count_next;
  logic               pop;
  logic [PTR_W-1:0]   tail_plus;

  // room for a full pair regardless of the reader
  assign room      = (count <= CNT_W'(FIFO_DEPTH - 2));
  assign out_valid = (count != '0);
  assign out_data  = slots[head];
  assign pop       = out_valid && out_ready;
  assign tail_plus = tail + PTR_W'(1);

  assign count_next = count + CNT_W'(push_num) - CNT_W'(pop);

  // store pushed words
  always_ff @(posedge clk) begin
    if (push_num != 2'd0) begin
      slots[tail] <= push_data.first;
    end
    if (push_num == 2'd2) begin
      slots[tail_plus] <= push_data.second;
    end
  end

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      tail  <= tail + PTR_W'(push_num);
      if (pop) begin
        head <= head + PTR_W'(1);
      end
    end
  end

  `MTD_ASSERT(a_no_overflow, count <= CNT_W'(FIFO_DEPTH), "result queue overflow")
  `MTD_ASSERT(a_push_room, push_num != 2'd0 |-> room, "push without room")
  `MTD_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> count == '0 && !out_valid, "queue not empty after reset")

endmodule

// ===== bench/morse_text_decoder_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse text decoder checker
// Watches both stream channels. Each accepted text word runs through a local
// decoder model that queues the characters it should produce. Each accepted
// result word is compared against the oldest queued character.
// ----------------------------------------------------------------------------
module morse_text_decoder_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
  input  logic       s_axis_tlast,   // end_of_stream
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,   // [7:0] out_char
  input  logic       m_axis_tuser,   // invalid_code
  input  logic       m_axis_tlast,   // last
  output int         mismatch_count,
  output int         pending_words
);
  import mtd_pkg::*;

  // letter and digit patterns: length, and dashes as ones with the first
  // symbol in bit 0
  logic [3:0] pat_len  [36];
  logic [7:0] pat_dash [36];

  // token and line state of the model
  logic [7:0] tok_dashes;
  logic [3:0] tok_len;
  logic       tok_slash;
  logic       tok_foreign;
  logic       line_busy;

  result_t    expected_chars [$];

  // build the pattern table from the Morse alphabet, a to z then 0 to 9
  initial begin
    string alphabet;
    int    idx;
    alphabet = {".- -... -.-. -.. . ..-. --. .... .. .--- -.- .-.. -- -. --- ",
                ".--. --.- .-. ... - ..- ...- .-- -..- -.-- --.. ",
                "----- .---- ..--- ...-- ....- ..... -.... --... ---.. ----."};
    idx = 0;
    for (int i = 0; i < 36; i++) begin
      pat_len[i]  = 4'd0;
      pat_dash[i] = 8'd0;
    end
    for (int k = 0; k < alphabet.len(); k++) begin
      if (alphabet[k] == " ") begin
        idx++;
      end else begin
        if (alphabet[k] == "-") pat_dash[idx][pat_len[idx]] = 1'b1;
        pat_len[idx] = pat_len[idx] + 4'd1;
      end
    end
  end

  function automatic void clear_token();
    tok_dashes  = 8'd0;
    tok_len     = 4'd0;
    tok_slash   = 1'b0;
    tok_foreign = 1'b0;
  endfunction

  function automatic void push_char(input logic [7:0] ch, input logic bad);
    result_t r;
    r.out_char     = ch;
    r.invalid_code = bad;
    r.last         = 1'b0;
    expected_chars.push_back(r);
  endfunction

  // turn a finished token into one character; an empty token gives nothing
  function automatic void resolve_token();
    logic [7:0] ch;
    logic       bad;
    if (tok_len == 4'd0) return;
    ch  = CH_STAR;
    bad = 1'b1;
    if (!tok_foreign) begin
      if (tok_slash) begin
        // only a lone slash is a word gap
        if (tok_len == 4'd1) begin
          ch  = CH_SPACE;
          bad = 1'b0;
        end
      end else if (tok_len == 4'd8 && tok_dashes == 8'd0) begin
        ch  = CH_HASH;
        bad = 1'b0;
      end else begin
        for (int i = 0; i < 36; i++) begin
          if (pat_len[i] == tok_len && pat_dash[i] == tok_dashes) begin
            ch  = (i < 26) ? 8'(8'h61 + i) : 8'(8'h30 + i - 26);
            bad = 1'b0;
          end
        end
      end
    end
    push_char(ch, bad);
    clear_token();
  endfunction

  // advance the model by one text word and queue what it yields
  function automatic void predict_word(input logic [7:0] b, input logic eos);
    int before_n;
    before_n = expected_chars.size();
    if (eos) begin
      resolve_token();
      if (line_busy) push_char(CH_NL, 1'b0);
      clear_token();
      line_busy = 1'b0;
    end else if (b == CH_NL) begin
      resolve_token();
      push_char(CH_NL, 1'b0);
      line_busy = 1'b0;
    end else if (b == CH_SPACE) begin
      line_busy = 1'b1;
      resolve_token();
    end else begin
      line_busy = 1'b1;
      if (b == CH_DASH && tok_len < 4'd8) tok_dashes[tok_len[2:0]] = 1'b1;
      else if (b == CH_SLASH) tok_slash = 1'b1;
      else if (b != CH_DOT && b != CH_DASH) tok_foreign = 1'b1;
      // count saturates; symbols past the eighth are not kept
      if (tok_len != 4'd15) tok_len = tok_len + 4'd1;
    end
    if (expected_chars.size() > before_n)
      expected_chars[expected_chars.size() - 1].last = 1'b1;
  endfunction

  // compare accepted results, then predict from accepted text
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_token();
      line_busy = 1'b0;
      expected_chars.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_chars.size() == 0) begin
          $error("result word with nothing expected: out_char %h", m_axis_tdata);
          mismatch_count++;
        end else begin
          want = expected_chars.pop_front();
          if (m_axis_tdata !== want.out_char) begin
            $error("out_char: expected %h, got %h", want.out_char, m_axis_tdata);
            mismatch_count++;
          end
          if (m_axis_tuser !== want.invalid_code) begin
            $error("invalid_code: expected %b, got %b", want.invalid_code,
                   m_axis_tuser);
            mismatch_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %b, got %b", want.last, m_axis_tlast);
            mismatch_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_word(s_axis_tdata, s_axis_tlast);
    end
    pending_words <= expected_chars.size();
  end

endmodule

// ===== bench/morse_text_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse text decoder testbench
// Feeds directed and random Morse text through the decoder with random gaps
// and stalls on both streams, one long output hold-off included. A checker
// beside the decoder predicts and compares every result word.
// ----------------------------------------------------------------------------
module morse_text_decoder_tb;
  import mtd_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int TOTAL_WORDS  = 2025;
  localparam int HOLD_AFTER   = 150;
  localparam int HOLD_CYCLES  = 250;
  localparam int DRAIN_CYCLES = 10;

  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'd0;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;
  logic       m_axis_tlast;

  int mismatch_count;
  int pending_words;
  int words_sent = 0;
  bit tx_steady  = 1'b0;

  morse_text_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  morse_text_decoder_checker decode_check (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tlast   (s_axis_tlast),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast),
    .mismatch_count (mismatch_count),
    .pending_words  (pending_words)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // hard stop if the run hangs
  initial begin
    #(CLK_PERIOD * 400000);
    $display("[FAIL] regression broken");
    $finish;
  end

  // offer one text word after a random gap and hold it until taken
  task automatic send_word(input logic [7:0] b, input logic eos);
    int gap;
    if ($urandom_range(0, 63) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
  endtask

  // random dots and dashes
  task automatic send_symbols(input int n);
    repeat (n) send_word($urandom_range(0, 1) ? CH_DASH : CH_DOT, 1'b0);
  endtask

  // receiver: random stalls, steady stretches, one long hold-off
  initial begin
    int gap;
    int taken;
    bit rx_steady;
    taken     = 0;
    rx_steady = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_steady = !rx_steady;
      if (taken == HOLD_AFTER) gap = HOLD_CYCLES;
      else gap = rx_steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      taken++;
    end
  end

  // stimulus and verdict
  initial begin
    int pick;
    int n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // table letter
    send_word(CH_DOT, 1'b0);
    send_word(CH_DASH, 1'b0);
    send_word(CH_SPACE, 1'b0);
    // eight dots, then newline
    repeat (8) send_word(CH_DOT, 1'b0);
    send_word(CH_NL, 1'b0);
    // lone slash, then a run of spaces
    send_word(CH_SLASH, 1'b0);
    send_word(CH_SPACE, 1'b0);
    send_word(CH_SPACE, 1'b0);
    // slash mixed with a dot
    send_word(CH_SLASH, 1'b0);
    send_word(CH_DOT, 1'b0);
    send_word(CH_NL, 1'b0);
    // foreign bytes, all bits low and all high
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(CH_SPACE, 1'b0);
    // empty line, then end of stream with nothing pending
    send_word(CH_NL, 1'b0);
    send_word(8'h00, 1'b1);
    // pending token and open line at end of stream
    send_word(CH_DASH, 1'b0);
    send_word(8'hFF, 1'b1);

    // random text: mostly well-formed tokens, some noise and broken tokens
    while (words_sent < TOTAL_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_symbols($urandom_range(1, 5));
      end else if (pick < 65) begin
        repeat (8) send_word(CH_DOT, 1'b0);
      end else if (pick < 70) begin
        send_word(CH_SLASH, 1'b0);
      end else if (pick < 76) begin
        send_symbols($urandom_range(6, 20));
      end else if (pick < 86) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          if ($urandom_range(0, 1)) send_word(8'($urandom_range(0, 255)), 1'b0);
          else send_symbols(1);
        end
      end else if (pick < 92) begin
        send_symbols($urandom_range(0, 2));
        send_word(CH_SLASH, 1'b0);
        send_symbols($urandom_range(0, 2));
      end else if (pick < 96) begin
        send_word(8'($urandom_range(0, 255)), 1'b1);
      end

      // end the token, or let it run into the next one
      pick = $urandom_range(0, 99);
      if (pick < 72) repeat ($urandom_range(1, 3)) send_word(CH_SPACE, 1'b0);
      else if (pick < 90) send_word(CH_NL, 1'b0);
      else if (pick < 95) send_word(8'($urandom_range(0, 255)), 1'b1);
    end

    // flush whatever is left and stop offering
    send_word(8'h00, 1'b1);
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
